// File: rtl/gsbc_pkg.sv
// Shared types and constants of the gas sensor baseline calibration unit.
`default_nettype none
package gsbc_pkg;
    localparam int unsigned PHASE_W   = 2;
    localparam int unsigned COUNT_W   = 24;
    localparam int unsigned SUM_W     = 56;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [PHASE_W-1:0] PH_START   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_SAMPLE  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_FINISH  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_OPERATE = 2'd3;

    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [1:0] REG_LOAD     = 2'd0;
    localparam logic [1:0] REG_SCALE    = 2'd1;
    localparam logic [1:0] REG_DURATION = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RS, ST_ACC, ST_DIV, ST_OUT
    } state_t;

    // lane division operation
    typedef enum logic [1:0] {
        OP_RS, OP_MEAN, OP_RATIO
    } div_op_t;

    typedef struct packed {
        logic    start;
        div_op_t op;
    } lane_ctrl_t;
endpackage
`default_nettype wire

// File: rtl/gsbc_lane.sv
// One channel lane: shared restoring divider for rs, mean and ratio.
`default_nettype none
module gsbc_lane #(
    parameter int unsigned ADC_BITS = 12
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire gsbc_pkg::lane_ctrl_t          ctrl,
    input  wire logic [ADC_BITS-1:0]           adc,
    input  wire logic [15:0]                   load,
    input  wire logic [31:0]                   product,
    input  wire logic [gsbc_pkg::SUM_W-1:0]    sum,
    input  wire logic [gsbc_pkg::COUNT_W-1:0]  count,
    input  wire logic [31:0]                   base,
    output logic                               busy,
    output logic [31:0]                        result
);
    localparam int unsigned DW = 64;
    localparam int unsigned CW = 7;

    logic [DW-1:0] quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    gsbc_pkg::div_op_t op_reg, op_next;
    logic busy_reg, busy_next;
    logic [31:0] res_reg, res_next;
    logic [DW:0] shifted;
    logic [DW:0] diff;
    logic [DW-1:0] dvd;
    logic [DW-1:0] dv;

    always_comb begin
        dvd = '0;
        dv  = '0;
        case (ctrl.op)
            gsbc_pkg::OP_RS: begin
                dvd = {32'd0, product};
                dv  = {{(DW-ADC_BITS){1'b0}}, adc};
            end
            gsbc_pkg::OP_MEAN: begin
                dvd = {8'd0, sum};
                dv  = {40'd0, count};
            end
            default: begin
                dvd = {16'd0, result, 16'd0};
                dv  = {32'd0, base};
            end
        endcase
    end

    assign shifted = {rem_reg[DW-1:0], quo_reg[DW-1]};
    assign diff = shifted - {1'b0, dvs_reg};

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        op_next = op_reg;
        busy_next = busy_reg;
        res_next = res_reg;
        if (ctrl.start) begin
            quo_next = dvd;
            rem_next = '0;
            dvs_next = dv;
            cnt_next = CW'(DW);
            op_next = ctrl.op;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (diff[DW]) begin
                rem_next = shifted;
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end else begin
                rem_next = diff;
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                case (op_reg)
                    gsbc_pkg::OP_RS: begin
                        if (dvs_reg == '0 || quo_next <= {48'd0, load})
                            res_next = '0;
                        else if (quo_next - {48'd0, load} > 64'hFFFF_FFFF)
                            res_next = '1;
                        else
                            res_next = 32'(quo_next - {48'd0, load});
                    end
                    default: res_next = (quo_next[DW-1:32] != '0) ? '1 : quo_next[31:0];
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        op_reg <= op_next;
        res_reg <= res_next;
    end

    assign busy = busy_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

// File: rtl/gas_sensor_baseline_calibration_unit.sv
// Top level of the gas sensor baseline calibration unit.
// channel   | direction | content
// s_axis    | in        | tuser=func, tdata=now_ms,adc_0..3
// m_axis    | out       | tdata=phase,samples_out,value_0..3,valid_mask
// apb       | in/out    | load resistance, full scale ratio, calibration length
// A start request goes from idle straight to the output state, which loads the result
// register. A calibration sample passes a launch state, a 64-step rs division in every lane
// with its accumulate state, then the output state. Ending calibration or an operating
// reading adds a second 64-step pass (mean or ratio) in the division state before output.
// Reset is synchronous, active low, and clears control, sums and baselines. One request is
// in flight at a time; s_tready returns once the result register loads, and a finished
// request waits in the output state while an earlier result is held by a low m_tready.
`default_nettype none
module gas_sensor_baseline_calibration_unit #(
    parameter int unsigned CHANNELS = 4,
    parameter int unsigned ADC_BITS = 12
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic         s_tuser,   // func
    // now_ms, adc_0, adc_1, adc_2, adc_3, zero fill
    input  wire logic [((32+4*ADC_BITS+7)/8)*8-1:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // phase, samples_out, value_0..3, valid_mask, zero fill
    output logic [159:0]      m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int unsigned NL = (CHANNELS < 4) ? CHANNELS : 4;
    localparam int unsigned SW = gsbc_pkg::SUM_W;

    logic [15:0] load_reg, scale_reg;
    logic [31:0] dur_reg;
    logic calib_reg;
    logic [31:0] start_reg;
    logic [gsbc_pkg::COUNT_W-1:0] count_reg;
    logic [SW-1:0] sum_reg [CHANNELS];
    logic [SW-1:0] sum_next [CHANNELS];
    logic [31:0] base_reg [CHANNELS];
    gsbc_pkg::state_t state_reg, state_next;
    logic func_reg;
    logic [31:0] now_reg;
    logic [ADC_BITS-1:0] adc_reg [CHANNELS];
    logic [31:0] product_reg;
    logic finish_reg;
    logic ratio_reg;
    logic [159:0] out_reg;
    logic ovalid_reg;
    logic out_load;
    logic [CHANNELS-1:0] busy;
    logic [31:0] lres [CHANNELS];
    gsbc_pkg::lane_ctrl_t ctrl;
    logic [1:0] rsel;
    logic accept;
    logic [gsbc_pkg::COUNT_W-1:0] count_new;
    logic [3:0] mask;
    logic [31:0] vals [4];

    assign pready = 1'b1;
    assign rsel = paddr[3:2];
    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == gsbc_pkg::ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata = out_reg;
    assign out_load = (state_reg == gsbc_pkg::ST_OUT) && (!ovalid_reg || m_tready);

    always_comb begin
        unique case (rsel)
            gsbc_pkg::REG_LOAD:     prdata = {16'd0, load_reg};
            gsbc_pkg::REG_SCALE:    prdata = {16'd0, scale_reg};
            gsbc_pkg::REG_DURATION: prdata = dur_reg;
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg <= 16'd1280;
            scale_reg <= 16'd6205;
            dur_reg <= 32'd172800000;
        end else if (psel && penable && pwrite) begin
            case (rsel)
                gsbc_pkg::REG_LOAD:     load_reg <= pwdata[15:0];
                gsbc_pkg::REG_SCALE:    scale_reg <= pwdata[15:0];
                gsbc_pkg::REG_DURATION: dur_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gsbc_pkg::ST_IDLE: if (accept)
                state_next = (s_tuser == gsbc_pkg::FUNC_START) ? gsbc_pkg::ST_OUT
                    : gsbc_pkg::ST_RS;
            gsbc_pkg::ST_RS: state_next = gsbc_pkg::ST_ACC;
            gsbc_pkg::ST_ACC: if (busy == '0)
                state_next = (finish_reg || ratio_reg) ? gsbc_pkg::ST_DIV
                    : gsbc_pkg::ST_OUT;
            gsbc_pkg::ST_DIV: if (busy == '0) state_next = gsbc_pkg::ST_OUT;
            gsbc_pkg::ST_OUT: if (out_load) state_next = gsbc_pkg::ST_IDLE;
            default: state_next = gsbc_pkg::ST_IDLE;
        endcase
    end

    // lane kick: rs pass on entry to ST_ACC, second pass on entry to ST_DIV
    always_comb begin
        ctrl.start = 1'b0;
        ctrl.op = gsbc_pkg::OP_RS;
        if (state_reg == gsbc_pkg::ST_RS) begin
            ctrl.start = 1'b1;
        end else if (state_reg == gsbc_pkg::ST_ACC && busy == '0
                     && (finish_reg || ratio_reg)) begin
            ctrl.start = 1'b1;
            ctrl.op = finish_reg ? gsbc_pkg::OP_MEAN : gsbc_pkg::OP_RATIO;
        end
    end

    assign count_new = (count_reg == gsbc_pkg::COUNT_MAX) ? count_reg : count_reg + 1'b1;

    // sums with this round's rs added; the mean pass divides these
    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            if (count_reg == gsbc_pkg::COUNT_MAX)
                sum_next[i] = sum_reg[i];
            else if ({1'b0, sum_reg[i]} + (SW+1)'(lres[i]) > {1'b0, {SW{1'b1}}})
                sum_next[i] = '1;
            else
                sum_next[i] = sum_reg[i] + SW'(lres[i]);
        end
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        gsbc_lane #(.ADC_BITS(ADC_BITS)) u_lane (
            .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .adc(adc_reg[g]),
            .load(load_reg), .product(product_reg), .sum(sum_next[g]),
            .count(count_new), .base(base_reg[g]), .busy(busy[g]), .result(lres[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gsbc_pkg::ST_IDLE;
            calib_reg <= 1'b0;
            start_reg <= '0;
            count_reg <= '0;
            ovalid_reg <= 1'b0;
            finish_reg <= 1'b0;
            ratio_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                sum_reg[i] <= '0;
                base_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (accept) begin
                func_reg <= s_tuser;
                now_reg <= s_tdata[31:0];
                for (int i = 0; i < CHANNELS; i++)
                    adc_reg[i] <= (i < 4) ? s_tdata[32+i*ADC_BITS +: ADC_BITS] : '0;
                product_reg <= load_reg * scale_reg;
                finish_reg <= 1'b0;
                ratio_reg <= 1'b0;
                if (s_tuser == gsbc_pkg::FUNC_START) begin
                    calib_reg <= 1'b1;
                    start_reg <= s_tdata[31:0];
                    count_reg <= '0;
                    for (int i = 0; i < CHANNELS; i++) sum_reg[i] <= '0;
                end else if (!calib_reg) begin
                    ratio_reg <= 1'b1;
                end
            end
            if (state_reg == gsbc_pkg::ST_RS && calib_reg) begin
                finish_reg <= (now_reg - start_reg) >= dur_reg;
            end
            if (state_reg == gsbc_pkg::ST_ACC && busy == '0 && calib_reg
                && func_reg == gsbc_pkg::FUNC_SAMPLE && !ctrl.start
                && !ratio_reg && count_reg != gsbc_pkg::COUNT_MAX && !finish_reg) begin
                count_reg <= count_new;
                for (int i = 0; i < CHANNELS; i++) sum_reg[i] <= sum_next[i];
            end
            if (ctrl.start && ctrl.op == gsbc_pkg::OP_MEAN
                && count_reg != gsbc_pkg::COUNT_MAX) begin
                count_reg <= count_new;
                for (int i = 0; i < CHANNELS; i++) sum_reg[i] <= sum_next[i];
            end
            if (out_load) begin
                ovalid_reg <= 1'b1;
                out_reg <= {2'd0, mask, vals[3], vals[2], vals[1], vals[0], count_reg,
                            func_reg == gsbc_pkg::FUNC_START ? gsbc_pkg::PH_START :
                            ratio_reg ? gsbc_pkg::PH_OPERATE :
                            finish_reg ? gsbc_pkg::PH_FINISH : gsbc_pkg::PH_SAMPLE};
                if (finish_reg) begin
                    calib_reg <= 1'b0;
                    for (int i = 0; i < CHANNELS; i++) base_reg[i] <= lres[i];
                end
            end else if (ovalid_reg && m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        mask = '0;
        for (int i = 0; i < 4; i++) begin
            vals[i] = '0;
            if (i < NL && func_reg == gsbc_pkg::FUNC_SAMPLE) begin
                if (finish_reg) begin
                    vals[i] = lres[i];
                    mask[i] = 1'b1;
                end else if (ratio_reg && base_reg[i] != '0) begin
                    vals[i] = lres[i];
                    mask[i] = 1'b1;
                end
            end
        end
    end

    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready) else $error("accepted while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed");
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_no_out_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy != '0) |-> !(state_reg == gsbc_pkg::ST_OUT)) else $error("early result");
endmodule
`default_nettype wire

// File: sim/gas_sensor_baseline_calibration_unit_tb.sv
// Self-checking testbench for the gas sensor baseline calibration unit.
`timescale 1ns / 100ps
`default_nettype none
module gas_sensor_baseline_calibration_unit_tb;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_LAT = 200;

    typedef struct packed {
        logic [1:0]  phase;
        logic [23:0] samples;
        logic [31:0] v0, v1, v2, v3;
        logic [3:0]  mask;
    } reading_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic         s_tuser = 1'b0;
    logic [79:0]  s_tdata = '0;
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    wire [159:0]  m_tdata;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    wire [31:0]   prdata;
    wire          pready;

    gas_sensor_baseline_calibration_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // predictor state
    logic [15:0] load_r, scale_r;
    logic [31:0] dur_r;
    logic        calib;
    logic [31:0] t_start;
    logic [23:0] n_samples;
    logic [55:0] sums [4];
    logic [31:0] base [4];

    reading_t expected_q[$];
    int errors = 0, mismatches = 0, n_results = 0, n_sent = 0, idle_cycles = 0;
    int n_finish = 0, n_operate = 0;
    bit ready_rand = 1'b1;

    function automatic logic [31:0] calc_rs(logic [11:0] adc);
        logic [63:0] q;
        if (adc == 0) return '0;
        q = (64'(load_r) * 64'(scale_r)) / 64'(adc);
        if (q <= 64'(load_r)) return '0;
        q = q - 64'(load_r);
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic reading_t predict_reading(logic fn, logic [31:0] now,
                                                 logic [11:0] adc [4]);
        reading_t r;
        logic [31:0] vals [4];
        logic [63:0] s, m, rt;
        logic [31:0] rs;
        r = '0;
        vals = '{default: '0};
        if (fn == gsbc_pkg::FUNC_START) begin
            calib = 1'b1;
            t_start = now;
            n_samples = '0;
            for (int i = 0; i < 4; i++) sums[i] = '0;
            r.phase = gsbc_pkg::PH_START;
        end else if (calib) begin
            if (n_samples < gsbc_pkg::COUNT_MAX) begin
                for (int i = 0; i < 4; i++) begin
                    s = 64'(sums[i]) + 64'(calc_rs(adc[i]));
                    sums[i] = (s > 64'h00FF_FFFF_FFFF_FFFF) ? 56'hFF_FFFF_FFFF_FFFF
                                                            : s[55:0];
                end
                n_samples++;
            end
            if ((now - t_start) >= dur_r) begin
                for (int i = 0; i < 4; i++) begin
                    if (n_samples > 0) begin
                        m = 64'(sums[i]) / 64'(n_samples);
                        base[i] = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
                    end
                    vals[i] = base[i];
                end
                r.mask = 4'hF;
                calib = 1'b0;
                r.phase = gsbc_pkg::PH_FINISH;
            end else begin
                r.phase = gsbc_pkg::PH_SAMPLE;
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                if (base[i] != 0) begin
                    rs = calc_rs(adc[i]);
                    rt = {rs, 16'h0} / 64'(base[i]);
                    vals[i] = (rt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rt[31:0];
                    r.mask[i] = 1'b1;
                end
            end
            r.phase = gsbc_pkg::PH_OPERATE;
        end
        r.samples = n_samples;
        r.v0 = vals[0]; r.v1 = vals[1]; r.v2 = vals[2]; r.v3 = vals[3];
        return r;
    endfunction

    task automatic gap(int short_max);
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, short_max);
        repeat (n) @(negedge aclk);
    endtask

    task automatic send_round(logic fn, logic [31:0] now, logic [11:0] a0, logic [11:0] a1,
                              logic [11:0] a2, logic [11:0] a3, int short_max = 3);
        logic [11:0] adc [4];
        adc = '{a0, a1, a2, a3};
        if (short_max > 0) gap(short_max);
        // the block is never ready right after an accept, so this costs no throughput
        @(negedge aclk);
        s_tuser <= fn;
        s_tdata <= {8'h00, a3, a2, a1, a0, now};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(predict_reading(fn, now, adc));
        n_sent++;
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (MAX_LAT) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            gsbc_pkg::REG_LOAD:  load_r = val[15:0];
            gsbc_pkg::REG_SCALE: scale_r = val[15:0];
            default:             dur_r = val;
        endcase
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic logic [11:0] rand_adc();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 12'hFFF;
            2: return 12'(1 << $urandom_range(0, 11));
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic test_defaults();
        // reset registers: reading before start, then a round at the full duration
        send_round(gsbc_pkg::FUNC_SAMPLE, 32'd5, 12'd100, 12'd0, 12'hFFF, 12'd1);
        send_round(gsbc_pkg::FUNC_START, 32'd1000, 12'd0, 12'd0, 12'd0, 12'd0);
        send_round(gsbc_pkg::FUNC_SAMPLE, 32'd1001, 12'd1, 12'd0, 12'hFFF, 12'd2048);
        send_round(gsbc_pkg::FUNC_SAMPLE, 32'd1000 + 32'd172800000,
                   12'd500, 12'd7, 12'hAAA, 12'h555);
        send_round(gsbc_pkg::FUNC_SAMPLE, 32'hFFFF_FFFF, 12'hFFF, 12'd1, 12'd3000, 12'd0);
        drain();
    endtask

    task automatic test_extremes();
        write_reg(gsbc_pkg::REG_LOAD, 32'hFFFF);
        write_reg(gsbc_pkg::REG_SCALE, 32'hFFFF);
        write_reg(gsbc_pkg::REG_DURATION, 32'hFFFF_FFFF);
        // wrapped elapsed time and largest rs values
        send_round(gsbc_pkg::FUNC_START, 32'hFFFF_FFF0, 12'd0, 12'd0, 12'd0, 12'd0);
        send_round(gsbc_pkg::FUNC_SAMPLE, 32'h0000_0010, 12'd1, 12'd2, 12'hFFF, 12'd0);
        send_round(gsbc_pkg::FUNC_SAMPLE, 32'hFFFF_FFEF, 12'd1, 12'd1, 12'd1, 12'd1);
        send_round(gsbc_pkg::FUNC_SAMPLE, 32'd0, 12'd1, 12'd1, 12'd1, 12'd1);
        send_round(gsbc_pkg::FUNC_SAMPLE, 32'd1, 12'd1, 12'hFFF, 12'd0, 12'd100);
        drain();
        write_reg(gsbc_pkg::REG_LOAD, 32'd1);
        write_reg(gsbc_pkg::REG_SCALE, 32'd1);
        write_reg(gsbc_pkg::REG_DURATION, 32'd0);
        // zero duration ends on first sample; all baselines zero afterwards
        send_round(gsbc_pkg::FUNC_SAMPLE, 32'd3, 12'd1, 12'd1, 12'd1, 12'd1);
        send_round(gsbc_pkg::FUNC_START, 32'd7, 12'd0, 12'd0, 12'd0, 12'd0);
        send_round(gsbc_pkg::FUNC_SAMPLE, 32'd7, 12'd1, 12'd2, 12'hFFF, 12'd0);
        send_round(gsbc_pkg::FUNC_SAMPLE, 32'd8, 12'd1, 12'd2, 12'hFFF, 12'd0);
        drain();
        write_reg(gsbc_pkg::REG_LOAD, 32'd1280);
        write_reg(gsbc_pkg::REG_SCALE, 32'd6205);
        write_reg(gsbc_pkg::REG_DURATION, 32'd1);
        send_round(gsbc_pkg::FUNC_START, 32'd50, 12'd0, 12'd0, 12'd0, 12'd0);
        send_round(gsbc_pkg::FUNC_SAMPLE, 32'd50, 12'd1000, 12'd1904, 12'd1, 12'hFFF);
        send_round(gsbc_pkg::FUNC_SAMPLE, 32'd51, 12'd2000, 12'd300, 12'd4, 12'd100);
        send_round(gsbc_pkg::FUNC_SAMPLE, 32'd52, 12'd1, 12'd0, 12'd4000, 12'd100);
        send_round(gsbc_pkg::FUNC_START, 32'd60, 12'd0, 12'd0, 12'd0, 12'd0);
        send_round(gsbc_pkg::FUNC_START, 32'd61, 12'd0, 12'd0, 12'd0, 12'd0);
        drain();
    endtask

    task automatic test_random(int items);
        int left, len;
        logic [31:0] now;
        left = items;
        while (left > 0) begin
            if ($urandom_range(0, 3) == 0) begin
                drain();
                write_reg(gsbc_pkg::REG_LOAD, ($urandom_range(0, 4) == 0) ? 32'hFFFF
                                    : 32'($urandom_range(1, 65535)));
                write_reg(gsbc_pkg::REG_SCALE, ($urandom_range(0, 4) == 0) ? 32'hFFFF
                                     : 32'($urandom_range(1, 65535)));
                write_reg(gsbc_pkg::REG_DURATION, 32'($urandom_range(0, 40)));
            end
            // calibration run: start, samples spaced a few ms, then operating rounds
            now = $urandom;
            send_round(gsbc_pkg::FUNC_START, now,
                       rand_adc(), rand_adc(), rand_adc(), rand_adc());
            len = $urandom_range(1, 25);
            for (int i = 0; i < len; i++) begin
                now = now + $urandom_range(0, 4);
                send_round(gsbc_pkg::FUNC_SAMPLE, now,
                           rand_adc(), rand_adc(), rand_adc(), rand_adc());
            end
            left -= 1 + len;
            len = $urandom_range(2, 20);
            for (int i = 0; i < len; i++)
                send_round(gsbc_pkg::FUNC_SAMPLE, $urandom,
                           rand_adc(), rand_adc(), rand_adc(), rand_adc(),
                           ($urandom_range(0, 4) == 0) ? 0 : 3);
            left -= len;
            if ($urandom_range(0, 7) == 0) begin
                // hold off until the block has caught up
                while (expected_q.size() != 0) @(negedge aclk);
            end
        end
        drain();
    endtask

    // result checker
    always @(posedge aclk) begin
        reading_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = '0;
            got.phase = m_tdata[1:0];
            got.samples = m_tdata[25:2];
            got.v0 = m_tdata[57:26];
            got.v1 = m_tdata[89:58];
            got.v2 = m_tdata[121:90];
            got.v3 = m_tdata[153:122];
            got.mask = m_tdata[157:154];
            n_results++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("ERROR: unexpected result %h", m_tdata);
            end else begin
                exp_r = expected_q.pop_front();
                if (exp_r.phase == gsbc_pkg::PH_FINISH) n_finish++;
                if (exp_r.phase == gsbc_pkg::PH_OPERATE) n_operate++;
                if (got !== exp_r) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("MISMATCH result %0d: exp ph=%0d n=%0d v=%h %h %h %h m=%h",
                                 n_results, exp_r.phase, exp_r.samples, exp_r.v0, exp_r.v1,
                                 exp_r.v2, exp_r.v3, exp_r.mask);
                        $display("    got ph=%0d n=%0d v=%h %h %h %h m=%h",
                                 got.phase, got.samples, got.v0, got.v1, got.v2, got.v3,
                                 got.mask);
                    end
                end
            end
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        if (!ready_rand) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        load_r = 16'd1280; scale_r = 16'd6205; dur_r = 32'd172800000;
        calib = 1'b0; t_start = '0; n_samples = '0;
        for (int i = 0; i < 4; i++) begin
            sums[i] = '0; base[i] = '0;
        end
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_defaults();
        ready_rand = 1'b0;
        test_extremes();
        ready_rand = 1'b1;
        test_random(1880);
        $display("Sent %0d rounds, checked %0d results (%0d calibration ends, %0d readings)",
                 n_sent, n_results, n_finish, n_operate);
        $display("Register settings varied across random calibration runs, errors: %0d", errors);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
